/* hdl/ptd_pkg.sv */
package ptd_pkg;

  localparam logic [31:0] FOREVER      = 32'hFFFF_FFFF;
  localparam logic [31:0] SAT_DEADLINE = 32'hFFFF_FFFE;
  localparam int          SLOT_XW      = 7;
  localparam int          MASK_W       = 16;

  typedef enum logic [2:0] {
    OP_DISPATCH     = 3'd0,
    OP_CREATE       = 3'd1,
    OP_DELETE       = 3'd2,
    OP_SUSPEND      = 3'd3,
    OP_RESUME       = 3'd4,
    OP_SUSP_FOREVER = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_USED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SWEEP,
    FSM_DRAIN
  } fsm_state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now;
    logic [3:0]  slot;
    logic [30:0] period;
    logic [30:0] first_delay;
    logic [31:0] delay;
  } ptd_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  created_slot;
    logic [15:0] fire_mask;
    logic [31:0] slack_ms;
  } ptd_out_t;

  typedef struct packed {
    logic [30:0] period;
    logic [31:0] time_left;
    logic [31:0] next_cmpl;
  } slot_rec_t;

  typedef struct packed {
    slot_rec_t   rec;
    logic [31:0] susp;
    logic        fired;
  } slot_upd_t;

  localparam int REC_W = $bits(slot_rec_t);

endpackage

/* hdl/ptd_mem.sv */
module ptd_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ptd_slot_alu.sv */
module ptd_slot_alu (
  input  ptd_pkg::slot_rec_t rec,
  input  logic [31:0]        susp,
  input  logic [31:0]        now,
  input  logic [31:0]        elapsed,
  output ptd_pkg::slot_upd_t upd
);
  import ptd_pkg::*;

  logic [31:0] susp_n;
  logic [33:0] diff;
  logic [31:0] tl_sat;
  logic        reload;

  always_comb begin
    susp_n = susp;
    if (susp != 32'd0 && susp != FOREVER && now >= susp) begin
      susp_n = 32'd0;
    end
    diff = {{2{rec.time_left[31]}}, rec.time_left} - {2'b00, elapsed};
    if (diff[33] && !(diff[32] && diff[31])) begin
      tl_sat = 32'h8000_0000;
    end else begin
      tl_sat = diff[31:0];
    end
    reload = tl_sat[31] || (tl_sat == 32'd0);

    upd.rec    = rec;
    upd.susp   = susp_n;
    upd.fired  = 1'b0;
    upd.rec.time_left = tl_sat;
    if (reload) begin
      upd.rec.time_left = tl_sat + {1'b0, rec.period};
      if (susp_n == 32'd0) begin
        upd.fired         = 1'b1;
        upd.rec.next_cmpl = now + {1'b0, rec.period};
      end
    end
  end

endmodule

/* hdl/periodic_task_dispatcher.sv */
// Non-dispatch requests: result strobed the cycle after acceptance; one request per cycle.
// Dispatch: busy through the SWEEP and DRAIN states, result strobed after DRAIN; set by the
//   sweep of the slot memories, one slot read-modify-write per cycle.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n, synchronous, active low) clears in-use bits, last dispatch time and
//   control; slot memories are not cleared.
module periodic_task_dispatcher #(
  parameter int TASK_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ptd_pkg::ptd_in_t  in_req,
  output logic              out_valid,
  output ptd_pkg::ptd_out_t out_rsp
);
  import ptd_pkg::*;

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  fsm_state_t              state_r, state_nxt;
  logic [TASK_SLOTS-1:0]   in_use_r, in_use_nxt;
  logic [31:0]             last_r;
  logic [31:0]             now_r;
  logic [31:0]             elapsed_r;
  logic [IW-1:0]           rd_idx_r;
  logic                    p1_v_r;
  logic [IW-1:0]           p1_idx_r;
  logic                    p2_v_r;
  logic                    p2_use_r;
  logic [31:0]             p2_nc_r;
  logic [MASK_W-1:0]       fire_r;
  logic                    found_r;
  logic [31:0]             best_r;
  logic                    out_valid_r;
  ptd_out_t                out_rsp_r;

  logic                    acc;
  logic                    disp_go;
  logic                    sweep;
  logic                    done;
  logic                    last_slot;
  ptd_out_t                rsp_nxt;
  logic                    rsp_valid_nxt;

  logic                    a_we, b_we;
  logic [IW-1:0]           a_waddr, b_waddr;
  logic [REC_W-1:0]        a_wdata, a_rdata;
  logic [31:0]             b_wdata, b_rdata;
  slot_rec_t               new_rec;
  slot_upd_t               upd;

  logic                    free_found;
  logic [IW-1:0]           free_idx;
  logic [SLOT_XW-1:0]      slot7;
  logic [SLOT_XW-1:0]      free7;
  logic [SLOT_XW-1:0]      p1_idx7;
  logic [IW-1:0]           tgt_idx;
  logic                    tgt_ok;
  logic [32:0]             susp_sum;
  logic [31:0]             susp_val;

  ptd_mem #(.DEPTH(TASK_SLOTS), .WIDTH(REC_W), .AW(IW)) u_rec_mem (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (rd_idx_r),
    .rdata (a_rdata)
  );

  ptd_mem #(.DEPTH(TASK_SLOTS), .WIDTH(32), .AW(IW)) u_susp_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (rd_idx_r),
    .rdata (b_rdata)
  );

  ptd_slot_alu u_alu (
    .rec     (slot_rec_t'(a_rdata)),
    .susp    (b_rdata),
    .now     (now_r),
    .elapsed (elapsed_r),
    .upd     (upd)
  );

  assign acc       = start && !busy;
  assign last_slot = (rd_idx_r == IW'(TASK_SLOTS - 1));

  always_comb begin
    unique case (state_r)
      FSM_IDLE:  state_nxt = disp_go ? FSM_SWEEP : FSM_IDLE;
      FSM_SWEEP: state_nxt = last_slot ? FSM_DRAIN : FSM_SWEEP;
      FSM_DRAIN: state_nxt = (!p1_v_r && !p2_v_r) ? FSM_IDLE : FSM_DRAIN;
      default:   state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    sweep = 1'b0;
    done  = 1'b0;
    unique case (state_r)
      FSM_IDLE:  busy = 1'b0;
      FSM_SWEEP: sweep = 1'b1;
      FSM_DRAIN: done = !p1_v_r && !p2_v_r;
      default:   busy = 1'b1;
    endcase
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign free7    = SLOT_XW'(free_idx);
  assign p1_idx7  = SLOT_XW'(p1_idx_r);
  assign slot7    = SLOT_XW'(in_req.slot);
  assign tgt_idx  = slot7[IW-1:0];
  assign tgt_ok   = (slot7 < SLOT_XW'(TASK_SLOTS)) && in_use_r[tgt_idx];
  assign susp_sum = {1'b0, in_req.now} + {1'b0, in_req.delay};

  always_comb begin
    if (in_req.delay == FOREVER) begin
      susp_val = FOREVER;
    end else if (susp_sum > {1'b0, SAT_DEADLINE}) begin
      susp_val = SAT_DEADLINE;
    end else begin
      susp_val = susp_sum[31:0];
    end
  end

  always_comb begin
    new_rec.period    = in_req.period;
    new_rec.time_left = {1'b0, in_req.first_delay};
    new_rec.next_cmpl = in_req.now + {1'b0, in_req.first_delay};

    in_use_nxt    = in_use_r;
    a_we          = p1_v_r && in_use_r[p1_idx_r];
    a_waddr       = p1_idx_r;
    a_wdata       = upd.rec;
    b_we          = p1_v_r && in_use_r[p1_idx_r];
    b_waddr       = p1_idx_r;
    b_wdata       = upd.susp;
    rsp_nxt       = '0;
    disp_go       = 1'b0;
    rsp_valid_nxt = acc && (in_req.operation != OP_DISPATCH);

    if (acc) begin
      unique case (op_t'(in_req.operation))
        OP_DISPATCH: disp_go = 1'b1;
        OP_CREATE: begin
          if (free_found) begin
            in_use_nxt[free_idx] = 1'b1;
            a_we                 = 1'b1;
            a_waddr              = free_idx;
            a_wdata              = new_rec;
            b_we                 = 1'b1;
            b_waddr              = free_idx;
            b_wdata              = FOREVER;
            rsp_nxt.created_slot = free7[3:0];
          end else begin
            rsp_nxt.status = ST_FULL;
          end
        end
        OP_DELETE: begin
          if (tgt_ok) begin
            in_use_nxt[tgt_idx] = 1'b0;
          end else begin
            rsp_nxt.status = ST_NOT_USED;
          end
        end
        OP_SUSPEND, OP_RESUME, OP_SUSP_FOREVER: begin
          if (tgt_ok) begin
            b_we    = 1'b1;
            b_waddr = tgt_idx;
            if (in_req.operation == OP_SUSPEND) begin
              b_wdata = susp_val;
            end else if (in_req.operation == OP_RESUME) begin
              b_wdata = 32'd0;
            end else begin
              b_wdata = FOREVER;
            end
          end else begin
            rsp_nxt.status = ST_NOT_USED;
          end
        end
        default: rsp_nxt.status = ST_OK;
      endcase
    end

    if (done) begin
      rsp_valid_nxt     = 1'b1;
      rsp_nxt.fire_mask = fire_r;
      rsp_nxt.slack_ms  = found_r ? (best_r - now_r) : FOREVER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      in_use_r    <= '0;
      last_r      <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      p1_v_r      <= sweep;
      p2_v_r      <= p1_v_r;
      out_valid_r <= rsp_valid_nxt;
      if (disp_go) begin
        last_r <= in_req.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= rsp_nxt;
    p1_idx_r  <= rd_idx_r;
    if (disp_go) begin
      now_r     <= in_req.now;
      elapsed_r <= in_req.now - last_r;
      rd_idx_r  <= '0;
      fire_r    <= '0;
      found_r   <= 1'b0;
      best_r    <= FOREVER;
    end else begin
      if (sweep && !last_slot) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
      if (p1_v_r && upd.fired && in_use_r[p1_idx_r] && (p1_idx7 < SLOT_XW'(MASK_W))) begin
        fire_r[p1_idx7[3:0]] <= 1'b1;
      end
      if (p2_v_r && p2_use_r && (p2_nc_r >= now_r) && (!found_r || (p2_nc_r < best_r))) begin
        found_r <= 1'b1;
        best_r  <= p2_nc_r;
      end
    end
    if (p1_v_r) begin
      p2_use_r <= in_use_r[p1_idx_r];
      p2_nc_r  <= upd.rec.next_cmpl;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTH
  a_disp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation == OP_DISPATCH) |=> busy)
    else $error("dispatch did not start the sweep");

  a_cmd_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation != OP_DISPATCH) |=> (out_valid && !busy))
    else $error("command result missing");

  a_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_no_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && sweep) |-> (p1_idx_r != rd_idx_r))
    else $error("write-back collides with read of same slot");
`endif

endmodule
